FILE: design/multipart_file_part_extractor_macros.svh
`ifndef MULTIPART_FILE_PART_EXTRACTOR_MACROS_SVH
`define MULTIPART_FILE_PART_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define MFPE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define MFPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mfpe_pkg.sv
package mfpe_pkg;

  localparam int MAX_BOUNDARY_DEF = 128;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  // "filename=" and CR LF CR LF
  localparam logic [3:0] KEY_LEN   = 4'd9;
  localparam logic [2:0] BLANK_LEN = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_CLOSE    = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;

  // work orders from front to back
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_BND  = 3'd1,
    OP_BND2 = 3'd2,
    OP_PAY  = 3'd3,
    OP_ERR  = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_body;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
  } out_word_t;

  // queue entry: optional clear, then one op
  typedef struct packed {
    logic       clr;
    op_t        op;
    logic [7:0] b0;
    logic [7:0] b1;
  } qent_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h66; // f
      4'd1:    c = 8'h69; // i
      4'd2:    c = 8'h6C; // l
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h6E; // n
      4'd5:    c = 8'h61; // a
      4'd6:    c = 8'h6D; // m
      4'd7:    c = 8'h65; // e
      4'd8:    c = 8'h3D; // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blank_char(input logic [1:0] idx);
    return idx[0] ? LF_BYTE : CR_BYTE;
  endfunction

endpackage

FILE: design/multipart_file_part_extractor.sv
// Multipart upload part extractor. Takes an upload body one word (byte) per
// cycle, while the queue is not full, on in_valid/in_ready and returns
// payload bytes, one closing-boundary word, or one boundary-too-long word on
// out_valid/out_ready. A front stage classifies each byte (boundary capture,
// filename= search, blank-line skip, payload) and hands work through a
// 4-entry queue to a back stage that keeps the boundary in compare cells and
// delays payload through a ring RAM by boundary length + 1 bytes. Throughput
// is one input byte per cycle unless the queue fills; results are registered
// through the queue register and then the ring RAM's registered read. Set
// start_of_body on the first byte of each body; bytes still inside the delay
// window when a body ends without its closing boundary are not emitted.
module multipart_file_part_extractor #(
  parameter int MAX_BOUNDARY = mfpe_pkg::MAX_BOUNDARY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfpe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfpe_pkg::out_word_t out_data
);
  import mfpe_pkg::*;

  logic  push;
  logic  q_full;
  qent_t push_data;
  logic  q_valid;
  logic  q_ready;
  qent_t q_data;

  mfpe_front #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mfpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  mfpe_back #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/mfpe_ram.sv
module mfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/mfpe_queue.sv
module mfpe_queue #(
  parameter int DEPTH = mfpe_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mfpe_pkg::qent_t push_data,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mfpe_pkg::qent_t pop_data
);
  import mfpe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rptr];
  assign pop       = pop_valid && pop_ready;

  // pointer wrap works for any depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

FILE: design/mfpe_front.sv
module mfpe_front #(
  parameter int MAX_BOUNDARY = mfpe_pkg::MAX_BOUNDARY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mfpe_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               push,
  output mfpe_pkg::qent_t    push_data
);
  import mfpe_pkg::*;

  localparam int LW = $clog2(MAX_BOUNDARY + 1);

  typedef enum logic [6:0] {
    PH_CAPTURE    = 7'b0000001,
    PH_CAPTURE_CR = 7'b0000010,
    PH_KEYWORD    = 7'b0000100,
    PH_SKIP_LINE  = 7'b0001000,
    PH_BLANK      = 7'b0010000,
    PH_PAYLOAD    = 7'b0100000,
    PH_HALT       = 7'b1000000
  } phase_t;

  phase_t        phase, phase_next, ph_eff;
  logic [LW-1:0] blen, blen_next, blen_eff;
  logic [3:0]    kcnt, kcnt_next, kcnt_eff;
  logic [2:0]    bcnt, bcnt_next, bcnt_eff;
  logic          accept;
  logic          clr;
  logic [7:0]    b;
  qent_t         ent;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (clr || ent.op != OP_NONE);
  assign push_data = ent;

  // classify one word; restart clears first
  always_comb begin
    b          = in_data.body_byte;
    clr        = in_data.start_of_body;
    ph_eff     = clr ? PH_CAPTURE : phase;
    blen_eff   = clr ? '0 : blen;
    kcnt_eff   = clr ? '0 : kcnt;
    bcnt_eff   = clr ? '0 : bcnt;
    phase_next = ph_eff;
    blen_next  = blen_eff;
    kcnt_next  = kcnt_eff;
    bcnt_next  = bcnt_eff;
    ent.clr    = clr;
    ent.op     = OP_NONE;
    ent.b0     = b;
    ent.b1     = b;
    unique case (ph_eff)
      PH_CAPTURE: begin
        if (b == CR_BYTE) begin
          phase_next = PH_CAPTURE_CR;
        end else if (blen_eff >= LW'(MAX_BOUNDARY)) begin
          ent.op     = OP_ERR;
          phase_next = PH_HALT;
        end else begin
          ent.op    = OP_BND;
          blen_next = blen_eff + LW'(1);
        end
      end
      PH_CAPTURE_CR: begin
        if (b == LF_BYTE) begin
          phase_next = PH_KEYWORD;
          kcnt_next  = '0;
        end else if (blen_eff >= LW'(MAX_BOUNDARY)) begin
          ent.op     = OP_ERR;
          phase_next = PH_HALT;
        end else if (b == CR_BYTE) begin
          // lone CR joins the boundary, next CR still pending
          ent.op    = OP_BND;
          ent.b0    = CR_BYTE;
          blen_next = blen_eff + LW'(1);
        end else if (blen_eff >= LW'(MAX_BOUNDARY - 1)) begin
          ent.op     = OP_ERR;
          phase_next = PH_HALT;
        end else begin
          ent.op     = OP_BND2;
          ent.b0     = CR_BYTE;
          blen_next  = blen_eff + LW'(2);
          phase_next = PH_CAPTURE;
        end
      end
      PH_KEYWORD: begin
        if (b == key_char(kcnt_eff)) begin
          kcnt_next = kcnt_eff + 4'd1;
        end else begin
          kcnt_next = (b == key_char(4'd0)) ? 4'd1 : 4'd0;
        end
        if (kcnt_next == KEY_LEN) begin
          phase_next = PH_SKIP_LINE;
        end
      end
      PH_SKIP_LINE: begin
        if (b == CR_BYTE) begin
          phase_next = PH_BLANK;
          bcnt_next  = '0;
        end
      end
      PH_BLANK: begin
        if (b == blank_char(bcnt_eff[1:0])) begin
          bcnt_next = bcnt_eff + 3'd1;
        end else begin
          bcnt_next = (b == CR_BYTE) ? 3'd1 : 3'd0;
        end
        if (bcnt_next == BLANK_LEN) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ent.op = OP_PAY;
      end
      PH_HALT: begin
        ent.op = OP_NONE;
      end
      default: begin
        phase_next = PH_CAPTURE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CAPTURE;
      blen  <= '0;
      kcnt  <= '0;
      bcnt  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      blen  <= blen_next;
      kcnt  <= kcnt_next;
      bcnt  <= bcnt_next;
    end
  end

`include "multipart_file_part_extractor_macros.svh"

  `MFPE_ASSERT(a_front_len_cap, 1'b1, blen <= LW'(MAX_BOUNDARY), "boundary count past limit")
  `MFPE_ASSERT(a_front_halt_quiet, accept && phase == PH_HALT && !in_data.start_of_body, !push, "work sent after error")
  `MFPE_ASSERT_NEXT(a_front_pay_hold, accept && phase == PH_PAYLOAD && !in_data.start_of_body, phase == PH_PAYLOAD, "left payload without restart")

endmodule

FILE: design/mfpe_back.sv
module mfpe_back #(
  parameter int MAX_BOUNDARY = mfpe_pkg::MAX_BOUNDARY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  mfpe_pkg::qent_t     q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfpe_pkg::out_word_t out_data
);
  import mfpe_pkg::*;

  localparam int LW     = $clog2(MAX_BOUNDARY + 1);
  localparam int NP     = MAX_BOUNDARY + 2;
  localparam int PW     = $clog2(NP);
  localparam int BIW    = $clog2(MAX_BOUNDARY);
  localparam int RAW    = $clog2(MAX_BOUNDARY + 2);
  localparam int RDEPTH = 2 ** RAW;

  logic [7:0]     bnd [MAX_BOUNDARY];
  logic [LW-1:0]  blen, blen_next, blen_eff;
  logic [NP-1:0]  pm, pm_next, pm_eff, pm_new;
  logic [PW-1:0]  cnt, cnt_next, cnt_eff;
  logic           done, done_next, done_eff;
  logic [RAW-1:0] wptr, wptr_next;
  logic           s2_valid;
  logic [1:0]     s2_kind;

  qent_t          e;
  logic           adv;
  logic [PW-1:0]  mpos;
  logic           match;
  logic           full;
  logic           has_res;
  logic [1:0]     res_kind;
  logic           ram_we, ram_re;
  logic [RAW-1:0] raddr;
  logic [7:0]     rdata;
  logic           bw0, bw1;
  logic [LW-1:0]  bi1_full;
  logic [BIW-1:0] bidx0, bidx1;

  assign e       = q_data;
  assign q_ready = !s2_valid || out_ready;
  assign adv     = q_valid && q_ready;

  assign blen_eff = e.clr ? '0 : blen;
  assign pm_eff   = e.clr ? '0 : pm;
  assign cnt_eff  = e.clr ? '0 : cnt;
  assign done_eff = e.clr ? 1'b0 : done;

  // prefix-match cells: cell k holds "last k+1 bytes equal CR LF boundary[0..k-2]"
  for (genvar k = 0; k < NP; k++) begin : g_cell
    if (k == 0) begin : g_cr
      assign pm_new[k] = (e.b0 == CR_BYTE);
    end else if (k == 1) begin : g_lf
      assign pm_new[k] = pm_eff[k-1] && (e.b0 == LF_BYTE);
    end else begin : g_bnd
      assign pm_new[k] = pm_eff[k-1] && (e.b0 == bnd[k-2]);
    end
  end

  assign mpos     = PW'(blen_eff) + PW'(1);
  assign match    = pm_new[mpos];
  assign full     = (cnt_eff >= mpos);
  assign bi1_full = blen_eff + LW'(1);
  assign bidx0    = blen_eff[BIW-1:0];
  assign bidx1    = bi1_full[BIW-1:0];
  // oldest window byte sits boundary length + 1 words behind the write pointer
  assign raddr    = wptr - RAW'(blen_eff) - RAW'(1);

  // execute one queued op
  always_comb begin
    blen_next = blen_eff;
    pm_next   = pm_eff;
    cnt_next  = cnt_eff;
    done_next = done_eff;
    wptr_next = wptr;
    has_res   = 1'b0;
    res_kind  = KIND_PAYLOAD;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    bw0       = 1'b0;
    bw1       = 1'b0;
    unique case (e.op)
      OP_NONE: begin
        has_res = 1'b0;
      end
      OP_BND: begin
        bw0       = 1'b1;
        blen_next = blen_eff + LW'(1);
      end
      OP_BND2: begin
        bw0       = 1'b1;
        bw1       = 1'b1;
        blen_next = blen_eff + LW'(2);
      end
      OP_PAY: begin
        if (!done_eff) begin
          pm_next   = pm_new;
          ram_we    = 1'b1;
          wptr_next = wptr + RAW'(1);
          if (full) begin
            has_res = 1'b1;
            if (match) begin
              res_kind  = KIND_CLOSE;
              done_next = 1'b1;
            end else begin
              ram_re = 1'b1;
            end
          end else begin
            cnt_next = cnt_eff + PW'(1);
          end
        end
      end
      OP_ERR: begin
        has_res  = 1'b1;
        res_kind = KIND_TOO_LONG;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blen     <= '0;
      pm       <= '0;
      cnt      <= '0;
      done     <= 1'b0;
      wptr     <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (adv) begin
        blen <= blen_next;
        pm   <= pm_next;
        cnt  <= cnt_next;
        done <= done_next;
        wptr <= wptr_next;
      end
      if (q_ready) begin
        s2_valid <= adv && has_res;
      end
    end
  end

  // boundary cells and result kind
  always_ff @(posedge clk) begin
    if (adv && bw0) begin
      bnd[bidx0] <= e.b0;
    end
    if (adv && bw1) begin
      bnd[bidx1] <= e.b1;
    end
    if (adv) begin
      s2_kind <= res_kind;
    end
  end

  // payload delay line
  mfpe_ram #(
    .WIDTH (8),
    .DEPTH (RDEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (adv && ram_we),
    .waddr (wptr),
    .wdata (e.b0),
    .re    (adv && ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid         = s2_valid;
  assign out_data.kind     = s2_kind;
  assign out_data.out_byte = (s2_kind == KIND_PAYLOAD) ? rdata : 8'h00;

`include "multipart_file_part_extractor_macros.svh"

  `MFPE_ASSERT(a_back_len_cap, 1'b1, blen <= LW'(MAX_BOUNDARY), "boundary length past limit")
  `MFPE_ASSERT(a_back_fill_cap, 1'b1, cnt <= PW'(blen) + PW'(1), "window fill past window")
  `MFPE_ASSERT_NEXT(a_back_close_done, adv && has_res && res_kind == KIND_CLOSE, done, "close seen but not done")
  `MFPE_ASSERT(a_back_done_quiet, adv && done && !e.clr, !(has_res && res_kind == KIND_PAYLOAD), "payload after close")

endmodule
